@@ src/ibs_pkg.sv @@
// ----------------------------------------------------------------------------
// ibs_pkg: shared types and constants of the issue bundle selector
// Candidate record, selector states and configuration register indexes.
// ----------------------------------------------------------------------------
package ibs_pkg;

  localparam int unsigned MaxCandsDef  = 16;
  localparam int unsigned WaveSlotsDef = 64;
  localparam int unsigned NumKinds     = 7;
  localparam logic [2:0]  NoGroup      = 3'd7;

  // configuration register indexes
  localparam logic [1:0] RegOrderMode  = 2'd0;
  localparam logic [1:0] RegTypeLimits = 2'd1;
  localparam logic [1:0] RegGrpLimits  = 2'd2;
  localparam logic [1:0] RegTypeGrpMap = 2'd3;

  localparam logic [27:0] TypeLimitsRst = 28'h1111111;
  localparam logic [27:0] GrpLimitsRst  = 28'h1111111;
  localparam logic [20:0] TypeGrpMapRst = 21'd1754760;

  typedef struct packed {
    logic        ready;
    logic [5:0]  wave;
    logic [2:0]  kind;
    logic [15:0] age;
    logic [7:0]  ident;
  } cand_t;

  typedef enum logic [2:0] {
    BkIdle,
    BkMod,
    BkWalk,
    BkEmit,
    BkNone
  } bk_state_e;

endpackage

@@ src/ibs_front.sv @@
// ----------------------------------------------------------------------------
// ibs_front: candidate loader
// Accepts candidate beats into the store, counts them, flags overflow and
// pushes a bundle descriptor into a small queue when a set closes.
// ----------------------------------------------------------------------------
module ibs_front #(
  parameter int unsigned MaxCands = ibs_pkg::MaxCandsDef,
  localparam int unsigned CntW = $clog2(MaxCands + 1),
  localparam int unsigned IdxW = $clog2(MaxCands)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid,
  output logic               in_ready,
  input  ibs_pkg::cand_t     cand_i,
  input  logic [7:0]         start_cursor_i,
  input  logic               set_end_i,
  // store write port toward the back end
  output logic               wr_en_o,
  output logic [IdxW-1:0]    wr_idx_o,
  // bundle descriptor queue, one entry
  output logic               bq_valid_o,
  input  logic               bq_ready_i,
  output logic [CntW-1:0]    bq_count_o,
  output logic [7:0]         bq_cursor_o,
  output logic               bq_ovf_o
);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            ovf_q, ovf_d;
  logic            bq_valid_q;
  logic [CntW-1:0] bq_count_q;
  logic [7:0]      bq_cursor_q;
  logic            bq_ovf_q;
  logic            acc, full;

  // the store is shared, so loading waits while a set is queued or selected
  assign in_ready = !bq_valid_q && bq_ready_i;
  assign acc      = in_valid && in_ready;
  assign full     = (cnt_q == CntW'(MaxCands));
  assign wr_en_o  = acc && !full;
  assign wr_idx_o = cnt_q[IdxW-1:0];

  // fill count and overflow for the set being loaded
  always_comb begin
    cnt_d = cnt_q;
    ovf_d = ovf_q;
    if (acc) begin
      if (set_end_i) begin
        cnt_d = '0;
        ovf_d = 1'b0;
      end else if (full) begin
        ovf_d = 1'b1;
      end else begin
        cnt_d = cnt_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      ovf_q      <= 1'b0;
      bq_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      ovf_q <= ovf_d;
      if (acc && set_end_i) bq_valid_q <= 1'b1;
      else if (bq_ready_i)  bq_valid_q <= 1'b0;
    end
  end

  // descriptor payload
  always_ff @(posedge clk_i) begin
    if (acc && set_end_i) begin
      bq_count_q  <= full ? cnt_q : cnt_q + CntW'(1);
      bq_cursor_q <= start_cursor_i;
      bq_ovf_q    <= ovf_q || full;
    end
  end

  assign bq_valid_o  = bq_valid_q;
  assign bq_count_o  = bq_count_q;
  assign bq_cursor_o = bq_cursor_q;
  assign bq_ovf_o    = bq_ovf_q;

endmodule

@@ src/ibs_back.sv @@
// ----------------------------------------------------------------------------
// ibs_back: greedy selector
// Reduces the cursor, walks the candidates one at a time in round robin or
// oldest first order, applies wave, type and group limits and emits picks.
// ----------------------------------------------------------------------------
module ibs_back #(
  parameter int unsigned MaxCands  = ibs_pkg::MaxCandsDef,
  parameter int unsigned WaveSlots = ibs_pkg::WaveSlotsDef,
  localparam int unsigned CntW = $clog2(MaxCands + 1),
  localparam int unsigned IdxW = $clog2(MaxCands)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [IdxW-1:0]  wr_idx_i,
  input  ibs_pkg::cand_t   wr_cand_i,
  input  logic             bq_valid_i,
  output logic             bq_ready_o,
  input  logic [CntW-1:0]  bq_count_i,
  input  logic [7:0]       bq_cursor_i,
  input  logic             bq_ovf_i,
  input  logic             order_mode_i,
  input  logic [27:0]      type_limits_i,
  input  logic [27:0]      grp_limits_i,
  input  logic [20:0]      type_grp_map_i,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       picked_ident_o,
  output logic             has_pick_o,
  output logic [3:0]       next_cursor_o,
  output logic             overflow_seen_o,
  output logic             bundle_end_o
);

  localparam int unsigned WsW  = (WaveSlots > 1) ? $clog2(WaveSlots) : 1;
  localparam int unsigned ModW = CntW + 7;

  // candidate store, in flip-flops
  ibs_pkg::cand_t store_q [MaxCands];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) store_q[wr_idx_i] <= wr_cand_i;
  end

  ibs_pkg::bk_state_e state_q, state_d;
  logic [CntW-1:0]  count_q;
  logic [7:0]       rem_q;
  logic [2:0]       sh_q;
  logic [ModW-1:0]  mod_sub;
  logic [IdxW-1:0]  pos_q;
  logic [CntW-1:0]  step_q;
  logic             mode_q, ovf_q;
  logic [MaxCands-1:0] visited_q;
  logic [WaveSlots-1:0] wave_used_q;
  logic [4:0]       tuse_q [ibs_pkg::NumKinds];
  logic [4:0]       guse_q [8];
  logic [IdxW-1:0]  start_q;
  logic             any_q;
  // pending pick, held until the next one or bundle end
  logic             pend_q;
  logic [7:0]       pend_id_q;
  // output register
  logic             ov_q;
  logic [7:0]       o_id_q;
  logic             o_has_q, o_end_q, o_ovf_q;
  logic [3:0]       o_cur_q;

  // oldest-first position: sequential min search is costly; use a small
  // registered scan per step instead: scan sub-state
  logic             scan_q;
  logic [IdxW-1:0]  scan_i_q, best_q;
  logic             found_q;

  ibs_pkg::cand_t cur;
  logic [2:0]  kind, grp;
  logic [3:0]  tlim, glim;
  logic [WsW-1:0] wslot;
  logic [WsW-1:0] slot_tab [64];
  logic        take;
  logic [IdxW-1:0] walk_pos;
  logic        out_free;
  logic [3:0]  nc;

  assign out_free = !ov_q || out_ready;

  // wave to tracking slot, a constant table over all wave numbers
  for (genvar g = 0; g < 64; g++) begin : g_slot
    assign slot_tab[g] = WsW'(g % WaveSlots);
  end

  // shifted count for the cursor reduction
  assign mod_sub = ModW'(count_q) << sh_q;

  // position currently examined by the greedy test
  assign walk_pos = mode_q ? best_q : pos_q;
  assign cur      = store_q[walk_pos];
  assign kind     = cur.kind;
  assign grp      = (kind == 3'd7) ? ibs_pkg::NoGroup : type_grp_map_i[3*kind+:3];
  assign wslot    = slot_tab[cur.wave];

  always_comb begin
    tlim = (kind == 3'd7) ? 4'd0 : type_limits_i[4*kind+:4];
    glim = (grp == ibs_pkg::NoGroup) ? 4'd0 : grp_limits_i[4*grp+:4];
    take = cur.ready && (kind != 3'd7) && !wave_used_q[wslot]
           && (tuse_q[kind[2:0] == 3'd7 ? 3'd0 : kind] < {1'b0, tlim})
           && (guse_q[grp] < {1'b0, glim});
  end

  // next cursor for this bundle
  always_comb begin
    nc = '0;
    if (!mode_q) begin
      if (any_q || (take && state_q == ibs_pkg::BkWalk && !scan_q))
        nc = 4'((CntW'(start_q) + CntW'(1) == count_q) ? '0 : start_q + IdxW'(1));
      else
        nc = 4'(start_q);
    end
  end

  logic walk_now, last_step, emit_now;
  assign walk_now  = (state_q == ibs_pkg::BkWalk) && !scan_q;
  assign last_step = (step_q + CntW'(1) == count_q);
  // a new pick pushes the previous one out
  assign emit_now  = walk_now && take && pend_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ibs_pkg::BkIdle: if (bq_valid_i) state_d = ibs_pkg::BkMod;
      ibs_pkg::BkMod:  if ({1'b0, rem_q} < 9'(count_q)) state_d = ibs_pkg::BkWalk;
      ibs_pkg::BkWalk: if (walk_now && last_step && (!emit_now || out_free))
                         state_d = ibs_pkg::BkEmit;
      ibs_pkg::BkEmit: if (out_free) state_d = ibs_pkg::BkIdle;
      ibs_pkg::BkNone: state_d = ibs_pkg::BkIdle;
      default:         state_d = ibs_pkg::BkIdle;
    endcase
  end

  assign bq_ready_o = (state_q == ibs_pkg::BkIdle);

  logic stall;
  assign stall = emit_now && !out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ibs_pkg::BkIdle;
      ov_q    <= 1'b0;
      pend_q  <= 1'b0;
      any_q   <= 1'b0;
      scan_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        ibs_pkg::BkIdle: begin
          if (bq_valid_i) begin
            count_q     <= bq_count_i;
            rem_q       <= bq_cursor_i;
            sh_q        <= 3'd7;
            mode_q      <= order_mode_i;
            ovf_q       <= bq_ovf_i;
            visited_q   <= '0;
            wave_used_q <= '0;
            for (int k = 0; k < int'(ibs_pkg::NumKinds); k++) tuse_q[k] <= '0;
            for (int k = 0; k < 8; k++) guse_q[k] <= '0;
            step_q      <= '0;
            pend_q      <= 1'b0;
            any_q       <= 1'b0;
          end
        end
        ibs_pkg::BkMod: begin
          // cursor mod count by shifted compare and subtract, at most 8 steps
          if ({1'b0, rem_q} >= 9'(count_q)) begin
            if (ModW'(rem_q) >= mod_sub) rem_q <= rem_q - mod_sub[7:0];
            sh_q <= sh_q - 3'd1;
          end else begin
            start_q  <= IdxW'(rem_q);
            pos_q    <= IdxW'(rem_q);
            scan_q   <= mode_q;
            scan_i_q <= '0;
            found_q  <= 1'b0;
          end
        end
        ibs_pkg::BkWalk: begin
          if (scan_q) begin
            // oldest-first search, one stored candidate a cycle
            if (!visited_q[scan_i_q]) begin
              if (!found_q ||
                  store_q[scan_i_q].age < store_q[best_q].age ||
                  (store_q[scan_i_q].age == store_q[best_q].age &&
                   store_q[scan_i_q].ident < store_q[best_q].ident)) begin
                best_q <= scan_i_q;
              end
              found_q <= 1'b1;
            end
            if (CntW'(scan_i_q) + CntW'(1) == count_q) scan_q <= 1'b0;
            else scan_i_q <= scan_i_q + IdxW'(1);
          end else if (!stall) begin
            if (take) begin
              wave_used_q[wslot] <= 1'b1;
              tuse_q[kind]       <= tuse_q[kind] + 5'd1;
              guse_q[grp]        <= guse_q[grp] + 5'd1;
              pend_q             <= 1'b1;
              pend_id_q          <= cur.ident;
              any_q              <= 1'b1;
            end
            if (mode_q) visited_q[best_q] <= 1'b1;
            step_q   <= step_q + CntW'(1);
            pos_q    <= (CntW'(pos_q) + CntW'(1) == count_q) ? '0 : pos_q + IdxW'(1);
            scan_q   <= mode_q;
            scan_i_q <= '0;
            found_q  <= 1'b0;
          end
        end
        ibs_pkg::BkEmit: ;
        ibs_pkg::BkNone: ;
        default: ;
      endcase
      if (emit_now && out_free) begin
        // emit the previous pick when a newer one arrives
        ov_q    <= 1'b1;
        o_id_q  <= pend_id_q;
        o_has_q <= 1'b1;
        o_end_q <= 1'b0;
        o_ovf_q <= ovf_q;
        o_cur_q <= nc;
      end else if (state_q == ibs_pkg::BkEmit && out_free) begin
        // final beat of the bundle
        ov_q    <= 1'b1;
        o_id_q  <= pend_q ? pend_id_q : 8'd0;
        o_has_q <= pend_q;
        o_end_q <= 1'b1;
        o_ovf_q <= ovf_q;
        o_cur_q <= nc;
      end else if (out_ready) begin
        ov_q    <= 1'b0;
      end
    end
  end

  assign out_valid       = ov_q;
  assign picked_ident_o  = o_id_q;
  assign has_pick_o      = o_has_q;
  assign next_cursor_o   = o_cur_q;
  assign overflow_seen_o = o_ovf_q;
  assign bundle_end_o    = o_end_q;

endmodule

@@ src/issue_bundle_selector_unit.sv @@
// ----------------------------------------------------------------------------
// issue_bundle_selector_unit: greedy issue bundle arbiter
// Loads candidates, then selects ready ones per wave, type and group limits.
// ----------------------------------------------------------------------------
// channel | handshake            | payload
// in      | in_valid / in_ready  | is_ready, wave_number, issue_kind, age_key,
//         |                      | cand_ident, start_cursor, set_end
// out     | out_valid/out_ready  | picked_ident, has_pick, next_cursor,
//         |                      | overflow_seen, bundle_end
// cfg     | cfg_we               | cfg_idx, cfg_data
// Candidates load one per cycle while the selector is idle and no set waits;
// a closed set waits in a one-entry queue until the selector takes it.
// Selection: cursor reduction by shifted subtract, then one walk step per
// candidate (oldest first adds a scan before each step), then a closing beat.
// Reset clears all control state; the store needs no clearing.
// A stalled output holds the walk; input stays blocked until the set is done.
module issue_bundle_selector_unit #(
  parameter int unsigned MaxCands  = ibs_pkg::MaxCandsDef,
  parameter int unsigned WaveSlots = ibs_pkg::WaveSlotsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        is_ready_i,
  input  logic [5:0]  wave_number_i,
  input  logic [2:0]  issue_kind_i,
  input  logic [15:0] age_key_i,
  input  logic [7:0]  cand_ident_i,
  input  logic [7:0]  start_cursor_i,
  input  logic        set_end_i,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  picked_ident_o,
  output logic        has_pick_o,
  output logic [3:0]  next_cursor_o,
  output logic        overflow_seen_o,
  output logic        bundle_end_o,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [27:0] cfg_data
);

  localparam int unsigned CntW = $clog2(MaxCands + 1);
  localparam int unsigned IdxW = $clog2(MaxCands);

  logic        mode_q;
  logic [27:0] tlim_q, glim_q;
  logic [20:0] map_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      tlim_q <= ibs_pkg::TypeLimitsRst;
      glim_q <= ibs_pkg::GrpLimitsRst;
      map_q  <= ibs_pkg::TypeGrpMapRst;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        ibs_pkg::RegOrderMode:  mode_q <= cfg_data[0];
        ibs_pkg::RegTypeLimits: tlim_q <= cfg_data;
        ibs_pkg::RegGrpLimits:  glim_q <= cfg_data;
        ibs_pkg::RegTypeGrpMap: map_q  <= cfg_data[20:0];
        default: ;
      endcase
    end
  end

  ibs_pkg::cand_t cand;
  assign cand = '{ready: is_ready_i, wave: wave_number_i, kind: issue_kind_i,
                  age: age_key_i, ident: cand_ident_i};

  logic            wr_en, bq_valid, bq_ready, bq_ovf;
  logic [IdxW-1:0] wr_idx;
  logic [CntW-1:0] bq_count;
  logic [7:0]      bq_cursor;

  ibs_front #(.MaxCands(MaxCands)) u_front (
    .clk_i, .rst_ni, .in_valid, .in_ready, .cand_i(cand),
    .start_cursor_i, .set_end_i,
    .wr_en_o(wr_en), .wr_idx_o(wr_idx),
    .bq_valid_o(bq_valid), .bq_ready_i(bq_ready),
    .bq_count_o(bq_count), .bq_cursor_o(bq_cursor), .bq_ovf_o(bq_ovf)
  );

  ibs_back #(.MaxCands(MaxCands), .WaveSlots(WaveSlots)) u_back (
    .clk_i, .rst_ni, .wr_en_i(wr_en), .wr_idx_i(wr_idx), .wr_cand_i(cand),
    .bq_valid_i(bq_valid), .bq_ready_o(bq_ready),
    .bq_count_i(bq_count), .bq_cursor_i(bq_cursor), .bq_ovf_i(bq_ovf),
    .order_mode_i(mode_q), .type_limits_i(tlim_q), .grp_limits_i(glim_q),
    .type_grp_map_i(map_q),
    .out_valid, .out_ready, .picked_ident_o, .has_pick_o, .next_cursor_o,
    .overflow_seen_o, .bundle_end_o
  );

endmodule

@@ src/ibs_checker.sv @@
// ----------------------------------------------------------------------------
// ibs_checker: port-level checks of the issue bundle selector
// Output handshake stability and bundle framing.
// ----------------------------------------------------------------------------
module ibs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] picked_ident_o,
  input logic       has_pick_o,
  input logic       bundle_end_o
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(picked_ident_o))
    else $error("result beat changed under stall");

  // an empty bundle is a single closing beat
  a_none_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !has_pick_o |-> bundle_end_o)
    else $error("empty result not closing the bundle");

  // an empty result carries identifier zero
  a_none_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !has_pick_o |-> picked_ident_o == 8'd0)
    else $error("empty result with nonzero identifier");

endmodule

bind issue_bundle_selector_unit ibs_checker u_ibs_checker (
  .clk_i, .rst_ni, .out_valid, .out_ready, .picked_ident_o, .has_pick_o,
  .bundle_end_o
);

@@ test/issue_bundle_selector_unit_tb.sv @@
// ----------------------------------------------------------------------------
// issue_bundle_selector_unit_tb: self-checking bench of the bundle selector
// Streams candidate sets through the block under several register settings
// and idle patterns. A behavioral selector predicts the picks of each set.
// ----------------------------------------------------------------------------
module issue_bundle_selector_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] ident;
    logic       has_pick;
    logic [3:0] cursor;
    logic       ovf;
    logic       last;
  } pick_t;

  int unsigned err_cnt = 0;

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    err_cnt++;
  endtask

  // selection predictor and store of expected picks
  class pick_board;
    ibs_pkg::cand_t cands[ibs_pkg::MaxCandsDef];
    int unsigned n_cands;
    bit          ovf;
    bit          oldest_mode;
    logic [27:0] type_lim;
    logic [27:0] grp_lim;
    logic [20:0] grp_map;
    pick_t       pending[$];

    function new();
      n_cands = 0; ovf = 0; oldest_mode = 0;
      type_lim = ibs_pkg::TypeLimitsRst; grp_lim = ibs_pkg::GrpLimitsRst;
      grp_map = ibs_pkg::TypeGrpMapRst;
    endfunction

    function void write_reg(logic [1:0] idx, logic [27:0] val);
      case (idx)
        ibs_pkg::RegOrderMode:  oldest_mode = val[0];
        ibs_pkg::RegTypeLimits: type_lim = val;
        ibs_pkg::RegGrpLimits:  grp_lim = val;
        ibs_pkg::RegTypeGrpMap: grp_map = val[20:0];
        default: ;
      endcase
    endfunction

    function void note_beat(ibs_pkg::cand_t c, logic [7:0] cur, bit last);
      logic [63:0] waves;
      int          tcnt[8];
      int          gcnt[8];
      bit          seen[ibs_pkg::MaxCandsDef];
      logic [7:0]  ids[$];
      int          start, pos, nxt;
      logic [2:0]  grp;
      int          tl, gl;
      pick_t       p;
      if (n_cands < ibs_pkg::MaxCandsDef) begin
        cands[n_cands] = c;
        n_cands++;
      end else ovf = 1;
      if (!last) return;
      waves = '0;
      foreach (tcnt[i]) begin tcnt[i] = 0; gcnt[i] = 0; end
      foreach (seen[i]) seen[i] = 0;
      start = cur % n_cands;
      for (int s = 0; s < n_cands; s++) begin
        if (!oldest_mode) pos = (start + s) % n_cands;
        else begin
          pos = -1;
          for (int i = 0; i < n_cands; i++) begin
            if (seen[i]) continue;
            if (pos < 0 || cands[i].age < cands[pos].age ||
                (cands[i].age == cands[pos].age && cands[i].ident < cands[pos].ident))
              pos = i;
          end
          seen[pos] = 1;
        end
        c = cands[pos];
        if (!c.ready || c.kind == 3'd7 || waves[c.wave]) continue;
        grp = grp_map[3*c.kind +: 3];
        tl = type_lim[4*c.kind +: 4];
        gl = (grp == ibs_pkg::NoGroup) ? 0 : grp_lim[4*grp +: 4];
        if (tcnt[c.kind] >= tl || gcnt[grp] >= gl) continue;
        waves[c.wave] = 1;
        tcnt[c.kind]++;
        gcnt[grp]++;
        ids = {ids, c.ident};
      end
      nxt = oldest_mode ? 0 : (ids.size() ? (start + 1) % n_cands : start);
      if (ids.size() == 0) begin
        p = '{8'd0, 1'b0, nxt[3:0], ovf, 1'b1};
        pending = {pending, p};
      end
      foreach (ids[k]) begin
        p = '{ids[k], 1'b1, nxt[3:0], ovf, k == ids.size() - 1};
        pending = {pending, p};
      end
      n_cands = 0;
      ovf = 0;
    endfunction

    function string check_pick(pick_t got);
      pick_t w;
      if (pending.size() == 0) return "result with nothing expected";
      w = pending.pop_front();
      if (got !== w)
        return $sformatf("id %0d/%0d pick %0d/%0d cur %0d/%0d ovf %0d/%0d end %0d/%0d",
          got.ident, w.ident, got.has_pick, w.has_pick, got.cursor, w.cursor,
          got.ovf, w.ovf, got.last, w.last);
      return "";
    endfunction
  endclass

  logic clk_i = 0, rst_ni = 0;
  logic in_valid = 0, in_ready, out_valid, out_ready = 0;
  logic is_ready_i = 0, set_end_i = 0;
  logic [5:0] wave_number_i = 0;
  logic [2:0] issue_kind_i = 0;
  logic [15:0] age_key_i = 0;
  logic [7:0] cand_ident_i = 0, start_cursor_i = 0;
  logic [7:0] picked_ident_o;
  logic has_pick_o, overflow_seen_o, bundle_end_o;
  logic [3:0] next_cursor_o;
  logic cfg_we = 0;
  logic [1:0] cfg_idx = 0;
  logic [27:0] cfg_data = 0;

  int send_idle = 0, recv_stall = 0;
  bit hold_off = 0;
  pick_board board = new();

  issue_bundle_selector_unit uut (.*);

  initial forever #4 clk_i = ~clk_i;

  // watchdog
  initial begin
    #40ms;
    $display("FAIL");
    $finish;
  end

  // receiver: random stall, optional long hold-off
  always @(posedge clk_i) begin
    string msg;
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        msg = board.check_pick('{picked_ident_o, has_pick_o, next_cursor_o,
                                 overflow_seen_o, bundle_end_o});
        if (msg != "") report_mismatch(msg);
      end
      out_ready <= !hold_off && ($urandom_range(99) >= recv_stall);
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [27:0] val);
    @(posedge clk_i);
    cfg_we <= 1; cfg_idx <= idx; cfg_data <= val;
    @(posedge clk_i);
    cfg_we <= 0;
    board.write_reg(idx, val);
  endtask

  task automatic send_beat(bit rdy, logic [5:0] wv, logic [2:0] kd, logic [15:0] ag,
                           logic [7:0] id, logic [7:0] cur, bit last);
    ibs_pkg::cand_t c;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk_i);
    end
    in_valid <= 1; is_ready_i <= rdy; wave_number_i <= wv; issue_kind_i <= kd;
    age_key_i <= ag; cand_ident_i <= id; start_cursor_i <= cur; set_end_i <= last;
    do @(posedge clk_i); while (!in_ready);
    c = '{rdy, wv, kd, ag, id};
    board.note_beat(c, cur, last);
  endtask

  // one set of n candidates; narrow fields give collisions on waves and ages
  task automatic send_set(int n, bit narrow);
    for (int i = 0; i < n; i++)
      send_beat($urandom_range(99) < 80,
                narrow ? 6'($urandom_range(5)) : 6'($urandom_range(63)),
                3'($urandom_range(7)),
                narrow ? 16'($urandom_range(3)) : 16'($urandom_range(65535)),
                8'($urandom_range(255)), 8'($urandom_range(255)), i == n - 1);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
  endtask

  initial begin
    int phase_items;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;
    // directed: extremes, single candidate, unusable kind, duplicate waves
    send_beat(1, 6'd63, 3'd6, 16'hffff, 8'hff, 8'hff, 1);
    send_beat(1, 6'd0, 3'd7, 16'h0, 8'h0, 8'h0, 1);
    send_beat(0, 6'd1, 3'd0, 16'd5, 8'd1, 8'd0, 1);
    for (int k = 0; k < 7; k++) send_beat(1, 6'(k), 3'(k), 16'(9 - k), 8'(k), 8'd3, k == 6);
    send_beat(1, 6'd4, 3'd2, 16'd1, 8'd10, 8'd0, 0);
    send_beat(1, 6'd4, 3'd2, 16'd1, 8'd9, 8'd200, 1);
    drain();
    // overflow: 18 candidates, set_end on a dropped one
    for (int k = 0; k < 18; k++)
      send_beat(1, 6'(k), 3'(k % 7), 16'd0, 8'(k), 8'd17, k == 17);
    drain();
    write_reg(ibs_pkg::RegOrderMode, 28'd1);
    write_reg(ibs_pkg::RegTypeLimits, 28'hfffffff);
    write_reg(ibs_pkg::RegGrpLimits, 28'hfffffff);
    write_reg(ibs_pkg::RegTypeGrpMap, 28'h1fffff);
    send_set(5, 1);
    drain();
    write_reg(ibs_pkg::RegTypeGrpMap, 28'd0);
    send_set(16, 1);
    drain();
    // random phases across settings and idle patterns
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(ibs_pkg::RegOrderMode, 28'(ph[0]));
      write_reg(ibs_pkg::RegTypeLimits,
                ph == 2 ? 28'd0 : 28'($urandom_range(28'hfffffff)));
      write_reg(ibs_pkg::RegGrpLimits,
                ph == 3 ? 28'hfffffff : 28'($urandom_range(28'hfffffff)));
      write_reg(ibs_pkg::RegTypeGrpMap, 28'($urandom_range(21'h1fffff)));
      send_idle = (ph % 4 == 1 || ph % 4 == 3) ? (ph % 4 == 3 ? 8 : 76) : 0;
      recv_stall = (ph % 4 == 2) ? 76 : (ph % 4 == 3 ? 8 : 0);
      if (ph == 4) fork
        begin hold_off = 1; repeat (3000) @(posedge clk_i); hold_off = 0; end
      join_none
      phase_items = 0;
      while (phase_items < 34) begin
        int n;
        n = ($urandom_range(9) == 0) ? $urandom_range(16, 18) : $urandom_range(1, 6);
        send_set(n, 1'($urandom_range(1)));
        phase_items += n;
      end
      drain();
    end
    if (err_cnt == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
